// ===== hdl/sfa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfa_pkg: shared definitions of the spring force accumulator
// Widths, opcodes, register indexes, unit status and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

    // Fixed point and store dimensions.
    localparam int FRAC_BITS     = 16;
    localparam int NUM_PARTICLES = 1024;
    localparam int PID_W         = 10;
    localparam int NUM_SPRINGS   = 4096;
    localparam int SID_W         = 12;
    localparam int WORD_W        = 32;
    localparam int COEF_W        = 31;
    localparam int MAG_W         = 31;
    localparam int SUM_W         = 64;
    localparam int ROOT_W        = 32;
    localparam int QUOT_W        = FRAC_BITS + 1;
    localparam int U_W           = FRAC_BITS + 2;

    // Item kinds carried in tuser.
    typedef enum logic [1:0] {
        OP_LOAD_POS   = 2'd0,
        OP_LOAD_VEL   = 2'd1,
        OP_SPRING     = 2'd2,
        OP_READ_FORCE = 2'd3
    } t_opcode;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIND_X = 2'd0;
    localparam logic [1:0] REG_WIND_Y = 2'd1;
    localparam logic [1:0] REG_WIND_Z = 2'd2;
    localparam logic [1:0] REG_BREAK  = 2'd3;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // Saturate a wide signed value to the 32-bit word range.
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sfa_isqrt.sv =====
// ----------------------------------------------------------------------------
// sfa_isqrt: iterative integer square root
// Floor square root of a 64-bit radicand, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_isqrt (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [sfa_pkg::SUM_W-1:0]        i_radicand,
    output sfa_pkg::t_unit_stat              o_stat,
    output logic [sfa_pkg::ROOT_W-1:0]       o_root
);

    localparam int REM_W = sfa_pkg::ROOT_W + 4;
    localparam int CNT_W = $clog2(sfa_pkg::ROOT_W);

    logic [sfa_pkg::SUM_W-1:0]  r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [sfa_pkg::ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    // Bring down two radicand bits and try the next root bit.
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[sfa_pkg::SUM_W-1 -: 2]};
    assign trial  = {{(REM_W-sfa_pkg::ROOT_W-2){1'b0}}, r_root, 2'b01};

    // One root bit each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad <= {r_rad[sfa_pkg::SUM_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[sfa_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[sfa_pkg::ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(sfa_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule

`default_nettype wire

// ===== hdl/sfa_udiv.sv =====
// ----------------------------------------------------------------------------
// sfa_udiv: unit vector component divider
// Computes (mag << FRAC_BITS) / len for mag not above len, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_udiv (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [sfa_pkg::MAG_W-1:0]        i_mag,
    input  wire  [sfa_pkg::MAG_W-1:0]        i_len,
    output sfa_pkg::t_unit_stat              o_stat,
    output logic [sfa_pkg::QUOT_W-1:0]       o_quot
);

    localparam int REM_W = sfa_pkg::MAG_W + 1;
    localparam int CNT_W = $clog2(sfa_pkg::QUOT_W);

    logic [REM_W-1:0]           r_rem;
    logic [sfa_pkg::QUOT_W-1:0] r_bits;
    logic [sfa_pkg::QUOT_W-1:0] r_quot;
    logic [sfa_pkg::MAG_W-1:0]  r_len;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [REM_W-1:0] rem_sh;

    // Since mag does not exceed len, the high part of the dividend starts below len.
    assign rem_sh = {r_rem[REM_W-2:0], r_bits[sfa_pkg::QUOT_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {2'b00, i_mag[sfa_pkg::MAG_W-1:1]};
                r_bits <= {i_mag[0], {sfa_pkg::FRAC_BITS{1'b0}}};
                r_quot <= '0;
                r_len  <= i_len;
            end else if (r_busy) begin
                r_bits <= {r_bits[sfa_pkg::QUOT_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, r_len}) begin
                    r_rem  <= rem_sh - {1'b0, r_len};
                    r_quot <= {r_quot[sfa_pkg::QUOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_quot <= {r_quot[sfa_pkg::QUOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(sfa_pkg::QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

`default_nettype wire

// ===== hdl/spring_force_accumulator.sv =====
// ----------------------------------------------------------------------------
// spring_force_accumulator: mass-spring-damper force accumulation with tearing
// Particle state in on-chip memories, one item worked on at a time.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one output transfer. Position and
// velocity loads go straight to the output state, a force read passes
// through a read state first. A spring item runs through a sequencer that
// reads both particles, squares and sums the offsets, takes a bit-serial
// square root, divides three unit-vector components one bit a cycle and
// then read-modify-writes the force of particle a and then particle b.
// After reset the torn-flag memory is cleared one entry a cycle, all 4096
// entries, and no input transfer is taken meanwhile; configuration writes
// are taken.
`default_nettype none

module spring_force_accumulator (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Input stream.
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // tdata from bit 0: particle_a, particle_b, spring_index, vec_x, vec_y,
    // vec_z, stiffness, rest_length, damping, zero fill.
    input  wire  [223:0] i_s_tdata,
    // tuser: opcode.
    input  wire  [1:0]   i_s_tuser,
    // Output stream.
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // tdata from bit 0: force_x, force_y, force_z.
    output logic [95:0]  o_m_tdata,
    // tuser: spring_torn.
    output logic [0:0]   o_m_tuser,
    // Configuration port.
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [3:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int W  = sfa_pkg::WORD_W;
    localparam int PW = sfa_pkg::PID_W;
    localparam int SW = sfa_pkg::SID_W;
    localparam int CW = sfa_pkg::COEF_W;
    localparam int MW = sfa_pkg::MAG_W;
    localparam int UW = sfa_pkg::U_W;
    localparam int DW = W + 1;
    localparam int DOT_W = DW + UW + 2;

    typedef logic signed [W-1:0] t_word;
    typedef logic signed [2:0][W-1:0] t_vec3;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_READ, S_RD_A, S_RD_B, S_CHECK, S_SQSUM, S_SQRT,
        S_DIV, S_DOT, S_COEF_S, S_COEF_P, S_COEF_Q, S_SUM_T, S_FORCE,
        S_UPD_A, S_UPD_B, S_OUT
    } t_state;

    // Input fields.
    logic [1:0]  in_op;
    logic [PW-1:0] in_a, in_b;
    logic [SW-1:0] in_si;
    t_vec3       in_vec;
    logic [CW-1:0] in_k, in_l0, in_c;

    assign in_op     = i_s_tuser;
    assign in_a      = i_s_tdata[9:0];
    assign in_b      = i_s_tdata[19:10];
    assign in_si     = i_s_tdata[31:20];
    assign in_vec[0] = i_s_tdata[63:32];
    assign in_vec[1] = i_s_tdata[95:64];
    assign in_vec[2] = i_s_tdata[127:96];
    assign in_k      = i_s_tdata[158:128];
    assign in_l0     = i_s_tdata[189:159];
    assign in_c      = i_s_tdata[220:190];

    // Configuration registers.
    t_word         r_wind_x, r_wind_y, r_wind_z;
    logic [CW-1:0] r_break;
    logic          cfg_we;

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind_x <= 32'sd131072;
            r_wind_y <= 32'sd327680;
            r_wind_z <= 32'sd0;
            r_break  <= 31'd131072;
        end else if (cfg_we) begin
            case (paddr[3:2])
                sfa_pkg::REG_WIND_X: r_wind_x <= pwdata;
                sfa_pkg::REG_WIND_Y: r_wind_y <= pwdata;
                sfa_pkg::REG_WIND_Z: r_wind_z <= pwdata;
                sfa_pkg::REG_BREAK:  r_break  <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (paddr[3:2])
            sfa_pkg::REG_WIND_X: prdata = r_wind_x;
            sfa_pkg::REG_WIND_Y: prdata = r_wind_y;
            sfa_pkg::REG_WIND_Z: prdata = r_wind_z;
            sfa_pkg::REG_BREAK:  prdata = {1'b0, r_break};
            default:             prdata = '0;
        endcase
    end

    // Sequencer registers.
    t_state        r_state;
    logic [PW-1:0] r_a, r_b;
    logic [SW-1:0] r_si;
    logic [CW-1:0] r_k, r_l0, r_c;
    t_vec3         r_pa, r_va;
    logic          r_torn_hit;
    logic signed [DW-1:0] r_d [3];
    logic signed [DW-1:0] r_dv [3];
    logic [MW-1:0] r_m [3];
    logic [sfa_pkg::SUM_W-1:0] r_sum;
    logic [MW-1:0] r_len;
    logic signed [UW-1:0] r_u [3];
    logic signed [DOT_W-1:0] r_dot;
    t_word         r_s, r_p, r_q, r_t;
    t_word         r_f [3];
    logic [1:0]    r_idx;
    logic [SW-1:0] r_clr;
    logic          r_sq_start, r_dv_start;
    t_vec3         r_res_f;
    logic          r_res_torn;
    logic          r_mv;
    t_vec3         r_mdata;
    logic          r_muser;

    // Memories and their read data.
    t_vec3 pos_mem [sfa_pkg::NUM_PARTICLES];
    t_vec3 vel_mem [sfa_pkg::NUM_PARTICLES];
    t_vec3 force_mem [sfa_pkg::NUM_PARTICLES];
    logic  torn_mem [sfa_pkg::NUM_SPRINGS];
    t_vec3 r_pos_rd, r_vel_rd, r_force_rd;
    logic  r_torn_rd;

    logic          accept;
    logic          a_ok, ab_ok, si_ok;
    logic [PW-1:0] pv_raddr, f_raddr;
    logic          f_we;
    logic [PW-1:0] f_waddr;
    t_vec3         f_wdata;
    logic          t_we;
    logic [SW-1:0] t_waddr;
    logic          t_wdata;
    logic          out_load;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_OUT) && (!r_mv || i_m_tready);

    // Id range checks.
    assign a_ok  = ({1'b0, in_a} < (PW+1)'(sfa_pkg::NUM_PARTICLES));
    assign ab_ok = a_ok && ({1'b0, in_b} < (PW+1)'(sfa_pkg::NUM_PARTICLES));
    assign si_ok = ({1'b0, in_si} < (SW+1)'(sfa_pkg::NUM_SPRINGS));

    // Arithmetic units.
    sfa_pkg::t_unit_stat sq_stat, dv_stat;
    logic [sfa_pkg::ROOT_W-1:0] sq_root;
    logic [sfa_pkg::QUOT_W-1:0] dv_quot;

    sfa_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_start),
        .i_radicand (r_sum),
        .o_stat     (sq_stat),
        .o_root     (sq_root)
    );

    sfa_udiv u_udiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dv_start),
        .i_mag   (r_m[r_idx]),
        .i_len   (r_len),
        .o_stat  (dv_stat),
        .o_quot  (dv_quot)
    );

    // Offset magnitudes for the tear check.
    logic [DW-1:0] mag [3];
    logic          far;
    always_comb begin
        far = 1'b0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = r_d[i][DW-1] ? DW'(-r_d[i]) : DW'(r_d[i]);
            if (mag[i] > {2'b00, r_break}) begin
                far = 1'b1;
            end
        end
    end

    // Datapath terms, one product per step.
    logic [sfa_pkg::SUM_W-1:0] sq_term;
    logic signed [DOT_W-1:0]   dot_term;
    logic signed [W-1:0]       k_s, c_s, ldiff;
    logic signed [63:0]        s_prod, q_prod, f_prod, dot_ext;
    logic signed [UW-1:0]      u_new;
    t_vec3                     upd_a, upd_b;

    always_comb begin
        sq_term  = 64'(r_m[r_idx]) * 64'(r_m[r_idx]);
        dot_term = r_dv[r_idx] * r_u[r_idx];
        k_s      = $signed({1'b0, r_k});
        c_s      = $signed({1'b0, r_c});
        ldiff    = $signed({1'b0, r_len}) - $signed({1'b0, r_l0});
        s_prod   = k_s * ldiff;
        q_prod   = c_s * r_p;
        f_prod   = r_t * r_u[r_idx];
        dot_ext  = r_dot;
        u_new    = r_d[r_idx][DW-1] ? -$signed({1'b0, dv_quot})
                                    : $signed({1'b0, dv_quot});
        for (int i = 0; i < 3; i++) begin
            upd_a[i] = sfa_pkg::sat32(64'($signed(r_force_rd[i])) - 64'(r_f[i]));
            upd_b[i] = sfa_pkg::sat32(64'($signed(r_force_rd[i])) + 64'(r_f[i]));
        end
    end

    // Memory addresses and write ports.
    always_comb begin
        pv_raddr = (r_state == S_RD_A) ? r_b : in_a;
        f_raddr  = in_a;
        if (r_state == S_FORCE) begin
            f_raddr = r_a;
        end else if (r_state == S_UPD_A) begin
            f_raddr = r_b;
        end
        f_we    = 1'b0;
        f_waddr = r_a;
        f_wdata = upd_a;
        if (accept && in_op == sfa_pkg::OP_LOAD_POS && a_ok) begin
            f_we    = 1'b1;
            f_waddr = in_a;
            f_wdata = {r_wind_z, r_wind_y, r_wind_x};
        end else if (r_state == S_UPD_A) begin
            f_we = 1'b1;
        end else if (r_state == S_UPD_B) begin
            f_we    = 1'b1;
            f_waddr = r_b;
            f_wdata = upd_b;
        end
        t_we    = 1'b0;
        t_waddr = r_si;
        t_wdata = 1'b1;
        if (r_state == S_CLEAR) begin
            t_we    = 1'b1;
            t_waddr = r_clr;
            t_wdata = 1'b0;
        end else if (r_state == S_CHECK && !r_torn_hit && far) begin
            t_we = 1'b1;
        end else if (r_state == S_SQRT && sq_stat.done
                     && sq_root > {1'b0, r_break}) begin
            t_we = 1'b1;
        end
    end

    // Particle memories.
    always_ff @(posedge i_clk) begin
        if (accept && in_op == sfa_pkg::OP_LOAD_POS && a_ok) begin
            pos_mem[in_a] <= in_vec;
        end
        if (accept && in_op == sfa_pkg::OP_LOAD_VEL && a_ok) begin
            vel_mem[in_a] <= in_vec;
        end
        if (f_we) begin
            force_mem[f_waddr] <= f_wdata;
        end
        r_pos_rd   <= pos_mem[pv_raddr];
        r_vel_rd   <= vel_mem[pv_raddr];
        r_force_rd <= force_mem[f_raddr];
    end

    // Torn flag memory.
    always_ff @(posedge i_clk) begin
        if (t_we) begin
            torn_mem[t_waddr] <= t_wdata;
        end
        r_torn_rd <= torn_mem[in_si];
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_sq_start <= 1'b0;
            r_dv_start <= 1'b0;
            r_mv       <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_sq_start <= 1'b0;
            r_dv_start <= 1'b0;
            if (r_mv && i_m_tready) begin
                r_mv <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SW'(sfa_pkg::NUM_SPRINGS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_a        <= in_a;
                        r_b        <= in_b;
                        r_si       <= in_si;
                        r_k        <= in_k;
                        r_l0       <= in_l0;
                        r_c        <= in_c;
                        r_res_f    <= '0;
                        r_res_torn <= 1'b0;
                        r_state    <= S_OUT;
                        if (in_op == sfa_pkg::OP_READ_FORCE && a_ok) begin
                            r_state <= S_READ;
                        end else if (in_op == sfa_pkg::OP_SPRING && ab_ok && si_ok
                                     && in_k != '0 && in_c != '0) begin
                            r_state <= S_RD_A;
                        end
                    end
                end
                S_READ: begin
                    r_res_f <= r_force_rd;
                    r_state <= S_OUT;
                end
                S_RD_A: begin
                    r_pa       <= r_pos_rd;
                    r_va       <= r_vel_rd;
                    r_torn_hit <= r_torn_rd;
                    r_state    <= S_RD_B;
                end
                S_RD_B: begin
                    for (int i = 0; i < 3; i++) begin
                        r_d[i]  <= DW'($signed(r_pa[i])) - DW'($signed(r_pos_rd[i]));
                        r_dv[i] <= DW'($signed(r_va[i])) - DW'($signed(r_vel_rd[i]));
                    end
                    r_state <= r_torn_hit ? S_OUT : S_CHECK;
                end
                S_CHECK: begin
                    // A component beyond the break length tears at once.
                    if (far) begin
                        r_res_torn <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= mag[i][MW-1:0];
                        end
                        r_sum   <= '0;
                        r_idx   <= '0;
                        r_state <= S_SQSUM;
                    end
                end
                S_SQSUM: begin
                    r_sum <= r_sum + sq_term;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == 2'd2) begin
                        r_sq_start <= 1'b1;
                        r_state    <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_stat.done) begin
                        if (sq_root > {1'b0, r_break}) begin
                            r_res_torn <= 1'b1;
                            r_state    <= S_OUT;
                        end else if (sq_root == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_len      <= sq_root[MW-1:0];
                            r_idx      <= '0;
                            r_dv_start <= 1'b1;
                            r_state    <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (dv_stat.done) begin
                        r_u[r_idx] <= u_new;
                        if (r_idx == 2'd2) begin
                            r_idx   <= '0;
                            r_dot   <= '0;
                            r_state <= S_DOT;
                        end else begin
                            r_idx      <= r_idx + 1'b1;
                            r_dv_start <= 1'b1;
                        end
                    end
                end
                S_DOT: begin
                    r_dot <= r_dot + dot_term;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == 2'd2) begin
                        r_state <= S_COEF_S;
                    end
                end
                S_COEF_S: begin
                    r_s     <= sfa_pkg::sat32(s_prod >>> sfa_pkg::FRAC_BITS);
                    r_state <= S_COEF_P;
                end
                S_COEF_P: begin
                    r_p     <= sfa_pkg::sat32(dot_ext >>> sfa_pkg::FRAC_BITS);
                    r_state <= S_COEF_Q;
                end
                S_COEF_Q: begin
                    r_q     <= sfa_pkg::sat32(q_prod >>> sfa_pkg::FRAC_BITS);
                    r_state <= S_SUM_T;
                end
                S_SUM_T: begin
                    r_t     <= sfa_pkg::sat32(64'(r_s) + 64'(r_q));
                    r_idx   <= '0;
                    r_state <= S_FORCE;
                end
                S_FORCE: begin
                    r_f[r_idx] <= sfa_pkg::sat32(f_prod >>> sfa_pkg::FRAC_BITS);
                    r_idx      <= r_idx + 1'b1;
                    if (r_idx == 2'd2) begin
                        r_state <= S_UPD_A;
                    end
                end
                S_UPD_A: begin
                    r_state <= S_UPD_B;
                end
                S_UPD_B: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_mv    <= 1'b1;
                        r_mdata <= r_res_f;
                        r_muser <= r_res_torn;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;

endmodule

`default_nettype wire
